// File: design/positional_list_with_run_scan_macros.svh
`ifndef POSITIONAL_LIST_WITH_RUN_SCAN_MACROS_SVH
`define POSITIONAL_LIST_WITH_RUN_SCAN_MACROS_SVH

// same-cycle implication, checked out of reset
`define PLRS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define PLRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: design/plrs_pkg.sv
package plrs_pkg;

    // fixed widths and defaults
    localparam int POS_W        = 7;
    localparam int MODE_W       = 3;
    localparam int CMD_W        = 13;
    localparam int DEPTH_DEF    = 64;
    localparam int DATA_W_DEF   = 32;

    // operation codes of the mode field
    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_REMOVE = 3'd1,
        MODE_READ   = 3'd2,
        MODE_SCAN   = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_BACK,
        S_EMIT
    } state_t;

    // operation broadcast along the chain
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic [CMD_W-1:0]   pos;
        logic [CMD_W-1:0]   cnt;
    } cell_cmd_t;

endpackage

// File: design/positional_list_with_run_scan.sv
// Positional list of signed words with increasing-run scan.
// Input channel in_valid/in_ready carries mode, position and value; output
// channel out_valid/out_ready carries data, ok, count and last per result.
// Storage is a chain of cells, one per entry; insert and remove shift every
// affected cell by one place at the same edge through neighbour links.
// For insert, remove, read, clear and unused modes the result is registered
// at the edge the transaction is accepted and shows next cycle.
// A scan first walks back from the position, one entry per cycle, to the
// run start and detects it there, then emits one result per cycle while the
// receiver is ready, from there to the run end.
// The next transaction is taken once the controller is idle and the output
// register is empty or being emptied.
// A stalled receiver holds the output register and freezes the emit phase.
// Reset empties the list (count 0) and clears the output valid; entry
// contents are unknown until written but never read before that.
module positional_list_with_run_scan
#(
    parameter int DEPTH  = plrs_pkg::DEPTH_DEF,
    parameter int DATA_W = plrs_pkg::DATA_W_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [plrs_pkg::MODE_W-1:0] mode,
    input  logic [plrs_pkg::POS_W-1:0] position,
    input  logic signed [DATA_W-1:0]   value,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DATA_W-1:0]   data,
    output logic                       ok,
    output logic [CNT_W-1:0]           count,
    output logic                       last
);
    import plrs_pkg::*;

`include "positional_list_with_run_scan_macros.svh"

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] data_reg, data_next;
    logic              ok_reg, ok_next;
    logic [CNT_W-1:0]  ocnt_reg, ocnt_next;
    logic              last_reg, last_next;

    logic [DATA_W-1:0] ent [DEPTH];
    logic [DEPTH-1:0]  inc;
    logic [DEPTH-1:0]  inc_up;
    cell_cmd_t         cmd;
    logic              accept, slot_free, pos_ok, full, out_load, emit_last;
    logic [IDX_W-1:0]  pidx;
    logic [CNT_W-1:0]  ins_pos;

    // chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] prev_e, next_e;
        if (i == 0)
        begin : g_first
            assign prev_e = '0;
        end
        else
        begin : g_mid
            assign prev_e = ent[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_end
            assign next_e    = ent[i];
            assign inc_up[i] = 1'b0;
        end
        else
        begin : g_rest
            assign next_e    = ent[i+1];
            assign inc_up[i] = inc[i+1];
        end
        plrs_cell #(
            .DATA_W (DATA_W),
            .DEPTH  (DEPTH),
            .INDEX  (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .value      (value),
            .prev_entry (prev_e),
            .next_entry (next_e),
            .entry      (ent[i]),
            .inc        (inc[i])
        );
    end

    // handshake and position checks
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign pos_ok    = CMP_W'(position) < CMP_W'(cnt_reg);
    assign full      = cnt_reg == CNT_W'(DEPTH);
    assign pidx      = IDX_W'(position);
    assign ins_pos   = pos_ok ? CNT_W'(position) : cnt_reg;
    assign emit_last = ((CNT_W'(idx_reg) + CNT_W'(1)) >= cnt_reg) || !inc_up[idx_reg];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && mode == MODE_SCAN && pos_ok)
                    state_next = S_BACK;
            end
            S_BACK:
            begin
                if (idx_reg == '0 || !inc[idx_reg])
                    state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (slot_free && emit_last)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cmd       = '{op: CELL_HOLD, pos: '0, cnt: CMD_W'(cnt_reg)};
        cnt_next  = cnt_reg;
        idx_next  = idx_reg;
        out_load  = 1'b0;
        data_next = data_reg;
        ok_next   = ok_reg;
        ocnt_next = ocnt_reg;
        last_next = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_load  = 1'b1;
                    data_next = '0;
                    ok_next   = 1'b0;
                    last_next = 1'b1;
                    case (mode)
                        MODE_INSERT:
                        begin
                            if (!full)
                            begin
                                cmd.op   = CELL_INSERT;
                                cmd.pos  = CMD_W'(ins_pos);
                                cnt_next = cnt_reg + CNT_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            if (pos_ok)
                            begin
                                cmd.op   = CELL_REMOVE;
                                cmd.pos  = CMD_W'(ins_pos);
                                cnt_next = cnt_reg - CNT_W'(1);
                                ok_next  = 1'b1;
                            end
                        end
                        MODE_READ:
                        begin
                            if (pos_ok)
                            begin
                                data_next = ent[pidx];
                                ok_next   = 1'b1;
                            end
                        end
                        MODE_SCAN:
                        begin
                            if (pos_ok)
                            begin
                                out_load = 1'b0;
                                idx_next = pidx;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            cnt_next = '0;
                            ok_next  = 1'b1;
                        end
                        default:
                            ok_next = 1'b0;
                    endcase
                    ocnt_next = cnt_next;
                end
            end
            S_BACK:
            begin
                if (idx_reg != '0 && inc[idx_reg])
                    idx_next = idx_reg - IDX_W'(1);
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_load  = 1'b1;
                    data_next = ent[idx_reg];
                    ok_next   = 1'b1;
                    ocnt_next = cnt_reg;
                    last_next = emit_last;
                    if (!emit_last)
                        idx_next = idx_reg + IDX_W'(1);
                end
            end
            default:
                idx_next = idx_reg;
        endcase
        out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        data_reg <= data_next;
        ok_reg   <= ok_next;
        ocnt_reg <= ocnt_next;
        last_reg <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign data      = data_reg;
    assign ok        = ok_reg;
    assign count     = ocnt_reg;
    assign last      = last_reg;

    // checks
    `PLRS_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(DEPTH))
    `PLRS_ASSERT_NEXT(a_back_flow, state_reg == S_BACK, state_reg == S_BACK || state_reg == S_EMIT)
    `PLRS_ASSERT_NEXT(a_insert_cnt, accept && mode == MODE_INSERT && !full, cnt_reg == $past(cnt_reg) + CNT_W'(1))

endmodule

// File: design/plrs_cell.sv
module plrs_cell #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 64,
    parameter int INDEX  = 0
) (
    input  logic                clk,
    input  plrs_pkg::cell_cmd_t cmd,
    input  logic [DATA_W-1:0]   value,
    input  logic [DATA_W-1:0]   prev_entry,
    input  logic [DATA_W-1:0]   next_entry,
    output logic [DATA_W-1:0]   entry,
    output logic                inc
);
    import plrs_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0] IDX = (CNT_W + 1)'(INDEX);

    logic [DATA_W-1:0] entry_reg;
    logic [DATA_W-1:0] entry_next;
    logic [CNT_W:0]    pos;
    logic [CNT_W:0]    cnt;

    assign pos = {1'b0, cmd.pos[CNT_W-1:0]};
    assign cnt = {1'b0, cmd.cnt[CNT_W-1:0]};

    // select own, neighbour or new value
    always_comb
    begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT:
            begin
                if (IDX == pos)
                    entry_next = value;
                else if (IDX > pos && IDX <= cnt)
                    entry_next = prev_entry;
            end
            CELL_REMOVE:
            begin
                if (IDX >= pos && IDX + 1'b1 < cnt)
                    entry_next = next_entry;
            end
            default:
                entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // signed rise from the left neighbour
    assign inc   = (INDEX != 0) && ($signed(prev_entry) < $signed(entry_reg));
    assign entry = entry_reg;

endmodule
